>>> hw/rtl/iirl_pkg.sv
package iirl_pkg;

    localparam int DEPTH  = 32;
    localparam int ELEM_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = $clog2(DEPTH);
    localparam int IDX_W  = 6;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic signed [ELEM_W-1:0] t_elem;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_DUMP   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [IDX_W-1:0]   index;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [4:0]         position;
        logic [5:0]         count;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        CK_HOLD,
        CK_APPEND,
        CK_INSERT,
        CK_REMOVE,
        CK_ROTATE
    } t_cell_kind;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_kind       kind;
        logic [CMP_W-1:0] idx;
        logic [CMP_W-1:0] count;
    } t_cell_cmd;

endpackage

>>> hw/rtl/iirl_cell.sv
module iirl_cell
    import iirl_pkg::*;
(
    input  logic             i_clk,
    input  logic [CMP_W-1:0] i_pos,
    input  t_cell_cmd        i_cmd,
    input  t_elem            i_value,
    input  t_elem            i_lower,
    input  t_elem            i_upper,
    input  t_elem            i_head,
    output t_elem            o_data
);

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.kind)
            CK_HOLD: begin
                n_data = r_data;
            end
            CK_APPEND: begin
                if (i_pos == i_cmd.count) begin
                    n_data = i_value;
                end
            end
            CK_INSERT: begin
                if (i_pos == i_cmd.idx) begin
                    n_data = i_value;
                end else if (i_pos > i_cmd.idx) begin
                    n_data = i_lower;
                end
            end
            CK_REMOVE: begin
                if (i_pos >= i_cmd.idx) begin
                    n_data = i_upper;
                end
            end
            CK_ROTATE: begin
                // filled part turns round by one, head wraps to the last filled cell
                if (i_pos + CMP_W'(1) == i_cmd.count) begin
                    n_data = i_head;
                end else begin
                    n_data = i_upper;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hw/rtl/indexed_insert_remove_list.sv
// results: append, insert, remove, clear, spare and rejected requests give their single result
// in the cycle after acceptance; a dump gives one result per cycle unless the output stalls.
// throughput: one request per cycle unless the output stalls; a dump holds the input until
// every entry has come out through the head cell as the cell chain rotates.
// reset: synchronous, active low; empties the list, entries stay undefined until written.
module indexed_insert_remove_list
    import iirl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;
    logic             r_out_valid;
    t_out             r_out;

    t_cell_cmd        cmd;
    t_elem            cell_data [DEPTH];
    t_elem            in_value;
    logic             slot_free;
    logic             accept;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             dump_last;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign idx_ext    = CMP_W'(i_in_data.index);
    assign cnt_ext    = CMP_W'(r_count);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign in_value   = ELEM_W'(i_in_data.value);
    assign dump_last  = (CNT_W'(r_pos) + CNT_W'(1) == r_count);

    always_comb begin
        cmd.kind  = CK_HOLD;
        cmd.idx   = idx_ext;
        cmd.count = cnt_ext;
        if (accept) begin
            case (i_in_data.mode)
                MODE_APPEND: if (!full) cmd.kind = CK_APPEND;
                MODE_INSERT: if (idx_ext <= cnt_ext && !full) cmd.kind = CK_INSERT;
                MODE_REMOVE: if (idx_ext < cnt_ext) cmd.kind = CK_REMOVE;
                default:     cmd.kind = CK_HOLD;
            endcase
        end else if (r_state == S_DUMP && slot_free) begin
            cmd.kind = CK_ROTATE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        iirl_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (CMP_W'(g)),
            .i_cmd   (cmd),
            .i_value (in_value),
            .i_lower (cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper (cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out_valid    <= 1'b1;
                        r_out.status   <= ST_OK;
                        r_out.element  <= '0;
                        r_out.position <= '0;
                        r_out.last     <= 1'b1;
                        r_out.count    <= 6'(r_count);
                        case (i_in_data.mode)
                            MODE_APPEND: begin
                                if (full) begin
                                    r_out.status <= ST_FULL;
                                end else begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_out.count <= 6'(r_count + CNT_W'(1));
                                end
                            end
                            MODE_INSERT: begin
                                if (idx_ext > cnt_ext) begin
                                    r_out.status <= ST_RANGE;
                                end else if (full) begin
                                    r_out.status <= ST_FULL;
                                end else begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_out.count <= 6'(r_count + CNT_W'(1));
                                end
                            end
                            MODE_REMOVE: begin
                                if (idx_ext >= cnt_ext) begin
                                    r_out.status <= ST_RANGE;
                                end else begin
                                    r_count     <= r_count - CNT_W'(1);
                                    r_out.count <= 6'(r_count - CNT_W'(1));
                                end
                            end
                            MODE_CLEAR: begin
                                r_count     <= '0;
                                r_out.count <= '0;
                            end
                            MODE_DUMP: begin
                                if (r_count == '0) begin
                                    r_out.status <= ST_EMPTY;
                                end else begin
                                    // results come from the dump state
                                    r_out_valid <= 1'b0;
                                    r_pos       <= '0;
                                    r_state     <= S_DUMP;
                                end
                            end
                            default: begin
                                r_out.status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_DUMP: begin
                    if (slot_free) begin
                        r_out_valid    <= 1'b1;
                        r_out.status   <= ST_OK;
                        r_out.element  <= 32'(cell_data[0]);
                        r_out.position <= 5'(r_pos);
                        r_out.count    <= 6'(r_count);
                        r_out.last     <= dump_last;
                        r_pos          <= r_pos + POS_W'(1);
                        if (dump_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> !o_in_ready)
        else $error("request taken during dump");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.last)
        else $error("error result not marked last");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP && slot_free && dump_last |=> r_state == S_IDLE)
        else $error("dump did not finish after its last entry");

endmodule

>>> tb/indexed_insert_remove_list_tb.sv
`timescale 1ns / 100ps

module indexed_insert_remove_list_tb;
    import iirl_pkg::*;

    // modes with no defined operation, the list must stay as it is
    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    localparam int RANDOM_REQUESTS = 220;
    localparam int MAX_REPORTS     = 10;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    class list_mirror;
        t_elem            store [DEPTH];
        int               used;
        t_out             awaited [$];
        int               mismatches;
        int               checked;
        int               full_rejects;

        function new();
            used = 0;
            foreach (store[k]) store[k] = '0;
            mismatches   = 0;
            checked      = 0;
            full_rejects = 0;
        endfunction

        function int held();
            return used;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // work out what one accepted request must produce
        function void note_request(t_in req);
            t_out res;
            int   j;
            int   idx;
            idx      = int'(req.index);
            res      = '0;
            res.last = 1'b1;
            case (req.mode)
                MODE_APPEND: begin
                    if (used >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        store[used] = req.value;
                        used        = used + 1;
                    end
                end
                MODE_INSERT: begin
                    // range check comes before the full check
                    if (idx > used) begin
                        res.status = ST_RANGE;
                    end else if (used >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (j = used; j > idx; j--) store[j] = store[j-1];
                        store[idx] = req.value;
                        used       = used + 1;
                    end
                end
                MODE_REMOVE: begin
                    if (idx >= used) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (j = idx; j + 1 < used; j++) store[j] = store[j+1];
                        used = used - 1;
                    end
                end
                MODE_CLEAR: begin
                    foreach (store[k]) store[k] = '0;
                    used = 0;
                end
                MODE_DUMP: begin
                    if (used == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        for (j = 0; j < used; j++) begin
                            res          = '0;
                            res.status   = ST_OK;
                            res.element  = store[j];
                            res.position = 5'(j);
                            res.count    = 6'(used);
                            res.last     = (j == used - 1);
                            awaited.push_back(res);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            if (res.status == ST_FULL) full_rejects++;
            res.count = 6'(used);
            awaited.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t unexpected result: status %0d element %0d pos %0d",
                             $realtime, got.status, got.element, got.position,
                             " count %0d last %0b", got.count, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.position !== want.position || got.count !== want.count ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%t result mismatch", $realtime);
                    $display("  expected: status %0d element %0d pos %0d count %0d last %0b",
                             want.status, want.element, want.position, want.count, want.last);
                    $display("  actual:   status %0d element %0d pos %0d count %0d last %0b",
                             got.status, got.element, got.position, got.count, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    list_mirror mirror;
    bit         steady;
    bit         growing;
    int         sent;
    int         dumps;

    indexed_insert_remove_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_request(input t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        mirror.note_request(req);
        sent++;
        if (req.mode == MODE_DUMP) dumps++;
    endtask

    task automatic idle_in();
        int gap;
        if (steady || $urandom_range(99) >= 35) return;
        gap = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(3, 1);
        i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send(input logic [2:0] mode, input int index, input logic signed [31:0] value);
        t_in req;
        req.mode  = mode;
        req.index = IDX_W'(index);
        req.value = value;
        push_request(req);
        idle_in();
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(19))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in random_request();
        t_in r;
        int  roll;
        int  n;
        n       = mirror.held();
        roll    = $urandom_range(99);
        r.index = IDX_W'($urandom_range(63));
        r.value = pick_value();
        if (roll < 7) begin
            r.mode = MODE_DUMP;
        end else if (roll < 8) begin
            r.mode = MODE_CLEAR;
        end else if (roll < 11) begin
            case ($urandom_range(2))
                0:       r.mode = MODE_SPARE_A;
                1:       r.mode = MODE_SPARE_B;
                default: r.mode = MODE_SPARE_C;
            endcase
        end else if ($urandom_range(99) < (growing ? 85 : 20)) begin
            r.mode = $urandom_range(1) ? MODE_APPEND : MODE_INSERT;
        end else begin
            r.mode = MODE_REMOVE;
        end
        // mostly legal positions, the rest anywhere in the field
        if ($urandom_range(99) < 85) begin
            if (r.mode == MODE_INSERT)
                r.index = IDX_W'($urandom_range(n));
            else if (r.mode == MODE_REMOVE && n > 0)
                r.index = IDX_W'($urandom_range(n - 1));
        end
        return r;
    endfunction

    // result side: check accepted results and stall at random
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) mirror.check_result(o_out_data);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!steady && $urandom_range(99) < 30) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 8)
                                                      : $urandom_range(2, 0);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_in req;
        int  done;
        int  full_tries;
        mirror     = new();
        steady     = 1'b0;
        growing    = 1'b1;
        sent       = 0;
        dumps      = 0;
        done       = 0;
        full_tries = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send(MODE_DUMP, 0, 0);
        send(MODE_REMOVE, 0, 0);
        send(MODE_INSERT, 1, 0);
        // extremes, insert at head, insert at the end acting as append
        send(MODE_INSERT, 0, VAL_MIN);
        send(MODE_APPEND, 0, VAL_MAX);
        send(MODE_INSERT, 2, -1);
        send(MODE_INSERT, 1, 0);
        send(MODE_APPEND, 63, 32'sh5555_5555);
        send(MODE_INSERT, 63, 32'sh2aaa_aaaa);
        send(MODE_REMOVE, 5, 0);
        send(MODE_REMOVE, 63, 0);
        send(MODE_DUMP, 63, -1);
        send(MODE_REMOVE, 0, 0);
        send(MODE_REMOVE, 3, 0);
        send(MODE_REMOVE, 1, 0);
        send(MODE_DUMP, 0, 0);
        send(MODE_SPARE_A, 63, -1);
        send(MODE_SPARE_B, 0, 0);
        send(MODE_SPARE_C, 63, VAL_MIN);
        send(MODE_CLEAR, 63, -1);
        send(MODE_DUMP, 0, 0);
        send(MODE_APPEND, 0, 32'shaaaa_aaaa);
        send(MODE_DUMP, 0, 0);

        // random walks between empty and full
        while (done < RANDOM_REQUESTS) begin
            if (mirror.held() == DEPTH) begin
                full_tries++;
                if (full_tries > 3) begin
                    growing    = 1'b0;
                    full_tries = 0;
                end
            end else begin
                full_tries = 0;
                if (mirror.held() == 0) growing = 1'b1;
            end
            if ($urandom_range(99) < 3) growing = !growing;
            if ($urandom_range(29) == 0) steady = !steady;
            req = random_request();
            push_request(req);
            idle_in();
            if (req.mode <= MODE_DUMP) done++;
        end

        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d requests sent, %0d of them dumps; %0d results checked",
                 sent, dumps, mirror.checked);
        $display("full list rejections seen: %0d, mismatches: %0d",
                 mirror.full_rejects, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/iirl_pkg.sv
hw/rtl/iirl_cell.sv
hw/rtl/indexed_insert_remove_list.sv
tb/indexed_insert_remove_list_tb.sv
